[rtl/jhmp_pkg.sv]
// Shared types, marker codes and helpers for the JPEG header marker parser.
package jhmp_pkg;

  localparam int MAX_COMPONENTS_DEF = 4;
  localparam int COMP_W             = 24;
  localparam int QUEUE_DEPTH_DEF    = 2;

  localparam logic [7:0] MK_FILL = 8'hFF;
  localparam logic [7:0] MK_SOI  = 8'hD8;
  localparam logic [7:0] MK_EOI  = 8'hD9;
  localparam logic [7:0] MK_SOS  = 8'hDA;
  localparam logic [7:0] MK_SOF0 = 8'hC0;
  localparam logic [7:0] MK_DHT  = 8'hC4;
  localparam logic [7:0] MK_JPG  = 8'hC8;
  localparam logic [7:0] MK_DAC  = 8'hCC;
  localparam logic [7:0] MK_APP0 = 8'hE0;
  localparam logic [7:0] MK_RST0 = 8'hD0;
  localparam logic [7:0] MK_RST7 = 8'hD7;
  localparam logic [7:0] MK_STUF = 8'h00;

  typedef enum logic [7:0] {
    PH_SOI0  = 8'b0000_0001,
    PH_SOI1  = 8'b0000_0010,
    PH_SCAN  = 8'b0000_0100,
    PH_CODE  = 8'b0000_1000,
    PH_LENHI = 8'b0001_0000,
    PH_LENLO = 8'b0010_0000,
    PH_BODY  = 8'b0100_0000,
    PH_DONE  = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic        baseline;
    logic [7:0]  precision;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  count;
    logic        has_jfif;
    logic [15:0] version;
    logic [7:0]  units;
    logic [15:0] x_density;
    logic [15:0] y_density;
  } run_info_t;

  localparam int INFO_W = $bits(run_info_t);

  localparam run_info_t INFO_RESET = '{
    baseline:  1'b0,
    precision: 8'd8,
    width:     16'd0,
    height:    16'd0,
    count:     8'd0,
    has_jfif:  1'b0,
    version:   16'd0,
    units:     8'd0,
    x_density: 16'd1,
    y_density: 16'd1
  };

  function automatic logic is_frame_code(input logic [7:0] c);
    return (c[7:4] == MK_SOF0[7:4]) && (c != MK_DHT) && (c != MK_JPG) && (c != MK_DAC);
  endfunction

  // "JFIF" followed by a zero byte
  function automatic logic [7:0] jfif_tag_byte(input logic [2:0] k);
    logic [7:0] t;
    unique case (k)
      3'd0:    t = 8'h4A;
      3'd1:    t = 8'h46;
      3'd2:    t = 8'h49;
      3'd3:    t = 8'h46;
      default: t = 8'h00;
    endcase
    return t;
  endfunction

endpackage

[rtl/jhmp_front.sv]
// Front end: byte acceptance, marker walk and collection of one run record per file.
module jhmp_front #(
  parameter int MAX_COMPONENTS = jhmp_pkg::MAX_COMPONENTS_DEF,
  parameter int CIW            = $clog2(MAX_COMPONENTS + 1)
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          accept,
  input  logic [7:0]                                    data_byte,
  input  logic                                          end_of_file,
  output logic                                          rec_push,
  output jhmp_pkg::run_info_t                           rec_info,
  output logic [CIW-1:0]                                rec_kept,
  output logic [MAX_COMPONENTS-1:0][jhmp_pkg::COMP_W-1:0] rec_comps
);

  localparam int CIXW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

  jhmp_pkg::phase_t phase, phase_next;
  logic [7:0]  marker_code, marker_code_next;
  logic [15:0] seg_len, seg_len_next;
  logic [15:0] seg_off, seg_off_next;
  logic        id_ok, id_ok_next;

  logic [7:0]  sf_precision, sf_precision_next;
  logic [15:0] sf_height, sf_height_next;
  logic [15:0] sf_width, sf_width_next;
  logic [7:0]  sf_count, sf_count_next;
  logic [CIW-1:0] comp_idx, comp_idx_next;
  logic [1:0]  comp_byte, comp_byte_next;
  logic [MAX_COMPONENTS-1:0][jhmp_pkg::COMP_W-1:0] staged_comps, staged_comps_next;

  logic [15:0] sj_version, sj_version_next;
  logic [7:0]  sj_units, sj_units_next;
  logic [15:0] sj_xd, sj_xd_next;
  logic [15:0] sj_yd, sj_yd_next;

  jhmp_pkg::run_info_t kept_info, kept_info_next;
  logic [CIW-1:0] kept_n, kept_n_next;
  logic [MAX_COMPONENTS-1:0][jhmp_pkg::COMP_W-1:0] kept_comps, kept_comps_next;

  logic        do_commit;
  logic [15:0] off_inc;
  logic [CIW-1:0] n_sel;

  assign off_inc = seg_off + 16'd1;

  always_comb begin
    phase_next        = phase;
    marker_code_next  = marker_code;
    seg_len_next      = seg_len;
    seg_off_next      = seg_off;
    id_ok_next        = id_ok;
    sf_precision_next = sf_precision;
    sf_height_next    = sf_height;
    sf_width_next     = sf_width;
    sf_count_next     = sf_count;
    comp_idx_next     = comp_idx;
    comp_byte_next    = comp_byte;
    staged_comps_next = staged_comps;
    sj_version_next   = sj_version;
    sj_units_next     = sj_units;
    sj_xd_next        = sj_xd;
    sj_yd_next        = sj_yd;
    kept_info_next    = kept_info;
    kept_n_next       = kept_n;
    kept_comps_next   = kept_comps;
    do_commit         = 1'b0;
    n_sel             = '0;

    if (accept) begin
      unique case (phase)
        jhmp_pkg::PH_SOI0: begin
          phase_next = (data_byte == jhmp_pkg::MK_FILL) ? jhmp_pkg::PH_SOI1 : jhmp_pkg::PH_DONE;
        end
        jhmp_pkg::PH_SOI1: begin
          phase_next = (data_byte == jhmp_pkg::MK_SOI) ? jhmp_pkg::PH_SCAN : jhmp_pkg::PH_DONE;
        end
        jhmp_pkg::PH_SCAN: begin
          if (data_byte == jhmp_pkg::MK_FILL) phase_next = jhmp_pkg::PH_CODE;
        end
        jhmp_pkg::PH_CODE: begin
          marker_code_next = data_byte;
          if (data_byte == jhmp_pkg::MK_EOI || data_byte == jhmp_pkg::MK_SOS) begin
            phase_next = jhmp_pkg::PH_DONE;
          end else if (data_byte == jhmp_pkg::MK_STUF ||
                       (data_byte >= jhmp_pkg::MK_RST0 && data_byte <= jhmp_pkg::MK_RST7)) begin
            phase_next = jhmp_pkg::PH_SCAN;
          end else begin
            phase_next = jhmp_pkg::PH_LENHI;
          end
        end
        jhmp_pkg::PH_LENHI: begin
          seg_len_next = {data_byte, 8'h00};
          phase_next   = jhmp_pkg::PH_LENLO;
        end
        jhmp_pkg::PH_LENLO: begin
          seg_len_next = {seg_len[15:8], data_byte};
          seg_off_next = '0;
          id_ok_next   = 1'b1;
          if (seg_len_next < 16'd2) begin
            phase_next = jhmp_pkg::PH_DONE;
          end else if (seg_len_next == 16'd2) begin
            do_commit  = 1'b1;
            phase_next = jhmp_pkg::PH_SCAN;
          end else begin
            phase_next = jhmp_pkg::PH_BODY;
          end
        end
        jhmp_pkg::PH_BODY: begin
          if (jhmp_pkg::is_frame_code(marker_code)) begin
            priority if (seg_off == 16'd0) begin
              sf_precision_next = data_byte;
            end else if (seg_off == 16'd1) begin
              sf_height_next[15:8] = data_byte;
            end else if (seg_off == 16'd2) begin
              sf_height_next[7:0] = data_byte;
            end else if (seg_off == 16'd3) begin
              sf_width_next[15:8] = data_byte;
            end else if (seg_off == 16'd4) begin
              sf_width_next[7:0] = data_byte;
            end else if (seg_off == 16'd5) begin
              sf_count_next  = data_byte;
              comp_idx_next  = '0;
              comp_byte_next = 2'd0;
            end else begin
              // component triples: count bytes in the triple, saturate the entry index
              if (comp_idx < CIW'(MAX_COMPONENTS)) begin
                unique case (comp_byte)
                  2'd0:    staged_comps_next[comp_idx[CIXW-1:0]][23:16] = data_byte;
                  2'd1:    staged_comps_next[comp_idx[CIXW-1:0]][15:8]  = data_byte;
                  default: staged_comps_next[comp_idx[CIXW-1:0]][7:0]   = data_byte;
                endcase
              end
              if (comp_byte == 2'd2) begin
                comp_byte_next = 2'd0;
                if (comp_idx < CIW'(MAX_COMPONENTS)) comp_idx_next = comp_idx + CIW'(1);
              end else begin
                comp_byte_next = comp_byte + 2'd1;
              end
            end
          end else if (marker_code == jhmp_pkg::MK_APP0) begin
            if (seg_off < 16'd5) begin
              if (data_byte != jhmp_pkg::jfif_tag_byte(seg_off[2:0])) id_ok_next = 1'b0;
            end else if (seg_off == 16'd5) begin
              sj_version_next[15:8] = data_byte;
            end else if (seg_off == 16'd6) begin
              sj_version_next[7:0] = data_byte;
            end else if (seg_off == 16'd7) begin
              sj_units_next = data_byte;
            end else if (seg_off == 16'd8) begin
              sj_xd_next[15:8] = data_byte;
            end else if (seg_off == 16'd9) begin
              sj_xd_next[7:0] = data_byte;
            end else if (seg_off == 16'd10) begin
              sj_yd_next[15:8] = data_byte;
            end else if (seg_off == 16'd11) begin
              sj_yd_next[7:0] = data_byte;
            end
          end
          seg_off_next = off_inc;
          if ({1'b0, off_inc} + 17'd2 >= {1'b0, seg_len}) begin
            do_commit  = 1'b1;
            phase_next = jhmp_pkg::PH_SCAN;
          end
        end
        jhmp_pkg::PH_DONE: begin
          phase_next = jhmp_pkg::PH_DONE;
        end
        default: begin
          phase_next = jhmp_pkg::PH_DONE;
        end
      endcase

      // completed triples equal the entries lying wholly inside the segment
      n_sel = (8'(comp_idx_next) < sf_count_next) ? comp_idx_next : CIW'(sf_count_next);

      if (do_commit) begin
        if (jhmp_pkg::is_frame_code(marker_code)) begin
          kept_info_next.baseline = (marker_code == jhmp_pkg::MK_SOF0);
          if (seg_len_next >= 16'd8) begin
            kept_info_next.precision = sf_precision_next;
            kept_info_next.height    = sf_height_next;
            kept_info_next.width     = sf_width_next;
            kept_info_next.count     = sf_count_next;
            kept_n_next              = n_sel;
            kept_comps_next          = staged_comps_next;
          end
        end else if (marker_code == jhmp_pkg::MK_APP0 && seg_len_next >= 16'd16 && id_ok_next) begin
          kept_info_next.has_jfif  = 1'b1;
          kept_info_next.version   = sj_version_next;
          kept_info_next.units     = sj_units_next;
          kept_info_next.x_density = sj_xd_next;
          kept_info_next.y_density = sj_yd_next;
        end
      end
    end

    rec_push  = accept && end_of_file;
    rec_info  = kept_info_next;
    rec_kept  = kept_n_next;
    rec_comps = kept_comps_next;
    if (!kept_info_next.baseline && kept_info_next.count == 8'd0) begin
      rec_info = '0;
      rec_kept = '0;
    end

    // start over for the next file
    if (accept && end_of_file) begin
      phase_next       = jhmp_pkg::PH_SOI0;
      marker_code_next = '0;
      seg_len_next     = '0;
      seg_off_next     = '0;
      id_ok_next       = 1'b0;
      kept_info_next   = jhmp_pkg::INFO_RESET;
      kept_n_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= jhmp_pkg::PH_SOI0;
      marker_code <= '0;
      seg_len     <= '0;
      seg_off     <= '0;
      id_ok       <= 1'b0;
      comp_idx    <= '0;
      comp_byte   <= 2'd0;
      kept_info   <= jhmp_pkg::INFO_RESET;
      kept_n      <= '0;
    end else begin
      phase       <= phase_next;
      marker_code <= marker_code_next;
      seg_len     <= seg_len_next;
      seg_off     <= seg_off_next;
      id_ok       <= id_ok_next;
      comp_idx    <= comp_idx_next;
      comp_byte   <= comp_byte_next;
      kept_info   <= kept_info_next;
      kept_n      <= kept_n_next;
    end
  end

  always_ff @(posedge clk) begin
    sf_precision <= sf_precision_next;
    sf_height    <= sf_height_next;
    sf_width     <= sf_width_next;
    sf_count     <= sf_count_next;
    staged_comps <= staged_comps_next;
    sj_version   <= sj_version_next;
    sj_units     <= sj_units_next;
    sj_xd        <= sj_xd_next;
    sj_yd        <= sj_yd_next;
    kept_comps   <= kept_comps_next;
  end

endmodule

[rtl/jhmp_queue.sv]
// Short record queue between the parsing front end and the result emitter.
module jhmp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = jhmp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    fill;

  assign full      = (fill == CW'(DEPTH));
  assign not_empty = (fill != '0);
  assign rdata     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      fill <= fill + CW'(1);
      else if (pop && !push) fill <= fill - CW'(1);
    end
  end

endmodule

[rtl/jhmp_back.sv]
// Back end: expands one run record into its result words behind an output register.
module jhmp_back #(
  parameter int MAX_COMPONENTS = jhmp_pkg::MAX_COMPONENTS_DEF,
  parameter int CIW            = $clog2(MAX_COMPONENTS + 1)
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            rec_valid,
  input  jhmp_pkg::run_info_t                             rec_info,
  input  logic [CIW-1:0]                                  rec_kept,
  input  logic [MAX_COMPONENTS-1:0][jhmp_pkg::COMP_W-1:0] rec_comps,
  output logic                                            rec_pop,
  output logic                                            out_valid,
  input  logic                                            out_stall,
  output logic                                            last,
  output jhmp_pkg::run_info_t                             out_info,
  output logic [jhmp_pkg::COMP_W-1:0]                     component_entry
);

  localparam int CIXW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

  logic [CIW-1:0] row;
  logic [CIW-1:0] rows;
  logic           row_last;
  logic           load;

  assign rows     = (rec_kept != '0) ? rec_kept : CIW'(1);
  assign row_last = (row == rows - CIW'(1));
  assign load     = rec_valid && (!out_valid || !out_stall);
  assign rec_pop  = load && row_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      row       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        row       <= row_last ? '0 : row + CIW'(1);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last            <= row_last;
      out_info        <= rec_info;
      component_entry <= (row < rec_kept) ? rec_comps[row[CIXW-1:0]] : '0;
    end
  end

endmodule

[rtl/jpeg_header_marker_parser.sv]
// Top level of the JPEG header marker parser: front end, record queue and emitter.
//
// Input channel: one file byte per word (data_byte), end_of_file set on the final
// byte. A word moves when in_valid is high and in_stall is low.
// Output channel: on the end-of-file byte the block queues one run record and then
// emits one result word per kept frame component, or a single word when none is
// kept; last marks the final word of the run. A word moves when out_valid is high
// and out_stall is low.
// Throughput: one input byte per cycle while in_stall is low. The front end walks
// the marker segments at one byte per clock; the emitter drains one result per clock
// while out_stall is low, from a two-entry record queue, so in_stall rises only when
// both queue entries are taken. The first result of a run passes through the queue,
// which takes the record on the edge that accepts the end-of-file byte, then the output
// register; further words of the run follow one per cycle while out_stall is low.
// A stalled output holds its word in the output register while the front end keeps
// parsing the next file.
// Reset: synchronous rst clears the walk, the kept frame and JFIF fields, the queue
// and out_valid; after each end-of-file byte the walk restarts by itself.
module jpeg_header_marker_parser #(
  parameter int MAX_COMPONENTS = jhmp_pkg::MAX_COMPONENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        last,
  output logic        baseline,
  output logic [7:0]  precision,
  output logic [15:0] image_width,
  output logic [15:0] image_height,
  output logic [7:0]  component_count,
  output logic        has_jfif,
  output logic [15:0] jfif_version,
  output logic [7:0]  density_units,
  output logic [15:0] x_density,
  output logic [15:0] y_density,
  output logic [23:0] component_entry
);

  localparam int CIW    = $clog2(MAX_COMPONENTS + 1);
  localparam int COMPSW = MAX_COMPONENTS * jhmp_pkg::COMP_W;
  localparam int QW     = jhmp_pkg::INFO_W + CIW + COMPSW;

  logic                                            accept;
  logic                                            q_full;
  logic                                            q_valid;
  logic                                            q_pop;
  logic                                            rec_push;
  jhmp_pkg::run_info_t                             rec_info;
  logic [CIW-1:0]                                  rec_kept;
  logic [MAX_COMPONENTS-1:0][jhmp_pkg::COMP_W-1:0] rec_comps;
  logic [QW-1:0]                                   q_wdata;
  logic [QW-1:0]                                   q_rdata;
  jhmp_pkg::run_info_t                             head_info;
  logic [CIW-1:0]                                  head_kept;
  logic [MAX_COMPONENTS-1:0][jhmp_pkg::COMP_W-1:0] head_comps;
  jhmp_pkg::run_info_t                             out_info;

  // hold input while both queued records wait for the emitter
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  jhmp_front #(
    .MAX_COMPONENTS (MAX_COMPONENTS),
    .CIW            (CIW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .end_of_file (end_of_file),
    .rec_push    (rec_push),
    .rec_info    (rec_info),
    .rec_kept    (rec_kept),
    .rec_comps   (rec_comps)
  );

  assign q_wdata = {rec_info, rec_kept, rec_comps};

  jhmp_queue #(
    .WIDTH (QW),
    .DEPTH (jhmp_pkg::QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (rec_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .rdata     (q_rdata)
  );

  // split the queue head back into its fields
  assign head_info  = jhmp_pkg::run_info_t'(q_rdata[QW-1 -: jhmp_pkg::INFO_W]);
  assign head_kept  = q_rdata[COMPSW +: CIW];
  assign head_comps = q_rdata[COMPSW-1:0];

  jhmp_back #(
    .MAX_COMPONENTS (MAX_COMPONENTS),
    .CIW            (CIW)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .rec_valid       (q_valid),
    .rec_info        (head_info),
    .rec_kept        (head_kept),
    .rec_comps       (head_comps),
    .rec_pop         (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .last            (last),
    .out_info        (out_info),
    .component_entry (component_entry)
  );

  assign baseline        = out_info.baseline;
  assign precision       = out_info.precision;
  assign image_width     = out_info.width;
  assign image_height    = out_info.height;
  assign component_count = out_info.count;
  assign has_jfif        = out_info.has_jfif;
  assign jfif_version    = out_info.version;
  assign density_units   = out_info.units;
  assign x_density       = out_info.x_density;
  assign y_density       = out_info.y_density;

endmodule

[rtl/jhmp_checker.sv]
// Port-level checks on the JPEG header marker parser, bound to the top level.
module jhmp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        last,
  input logic        baseline,
  input logic [7:0]  precision,
  input logic [15:0] image_width,
  input logic [15:0] image_height,
  input logic [7:0]  component_count,
  input logic        has_jfif,
  input logic [15:0] jfif_version,
  input logic [7:0]  density_units,
  input logic [15:0] x_density,
  input logic [15:0] y_density,
  input logic [23:0] component_entry
);

  // drop any pending output on reset
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // hold the stalled result word
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(last) && $stable(component_entry))
    else $error("stalled result word changed");

  // a run without a frame gives one all-zero word
  a_no_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !baseline && component_count == 8'd0 |->
      last && precision == 8'd0 && image_width == 16'd0 && image_height == 16'd0 &&
      !has_jfif && density_units == 8'd0 && component_entry == 24'd0)
    else $error("no-frame result not zeroed");

  // without JFIF, densities are one, or zero in the no-frame word
  a_no_jfif_density: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_jfif |->
      (x_density == 16'd1 && y_density == 16'd1 && jfif_version == 16'd0) ||
      (x_density == 16'd0 && y_density == 16'd0 && jfif_version == 16'd0))
    else $error("density fields wrong without JFIF");

endmodule

bind jpeg_header_marker_parser jhmp_checker u_jhmp_checker (.*);

[tb/sv/jpeg_header_marker_parser_tb.sv]
// Self-checking testbench for the JPEG header marker parser: directed files, then random files.
module jpeg_header_marker_parser_tb;

  localparam int          COMPS         = jhmp_pkg::MAX_COMPONENTS_DEF;
  localparam int          FRAME_HDR_LEN = 8;   // length field plus precision, size and count
  localparam int          JFIF_MIN_LEN  = 16;  // length field plus the fixed JFIF body
  localparam logic [39:0] JFIF_ID       = 40'h4A_46_49_46_00;
  localparam logic [7:0]  MK_SOF1       = 8'hC1;
  localparam logic [7:0]  MK_SOF2       = 8'hC2;
  localparam logic [7:0]  MK_SOF_LAST   = 8'hCF;
  localparam logic [7:0]  MK_DQT        = 8'hDB;
  localparam logic [7:0]  MK_APP1       = 8'hE1;
  localparam logic [7:0]  MK_COM        = 8'hFE;

  // One result word as the output channel carries it.
  typedef struct packed {
    logic        last;
    logic        baseline;
    logic [7:0]  precision;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  component_count;
    logic        has_jfif;
    logic [15:0] jfif_version;
    logic [7:0]  density_units;
    logic [15:0] x_density;
    logic [15:0] y_density;
    logic [23:0] component_entry;
  } run_word_t;

  typedef struct packed {
    logic        baseline;
    logic [7:0]  precision;
    logic [15:0] height;
    logic [15:0] width;
    logic [7:0]  count;   // declared in the header
    logic [2:0]  kept;    // entries actually held
  } frame_rec_t;

  typedef struct packed {
    logic        present;
    logic [15:0] version;
    logic [7:0]  units;
    logic [15:0] xd;
    logic [15:0] yd;
  } jfif_rec_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        end_of_file;
  logic        out_valid;
  logic        out_stall;
  logic        last;
  logic        baseline;
  logic [7:0]  precision;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [7:0]  component_count;
  logic        has_jfif;
  logic [15:0] jfif_version;
  logic [7:0]  density_units;
  logic [15:0] x_density;
  logic [15:0] y_density;
  logic [23:0] component_entry;

  // Walk state of the predictor, mirroring the block's own.
  jhmp_pkg::phase_t walk_phase;
  logic [7:0]  seg_marker;
  logic [15:0] seg_len;
  logic [15:0] seg_pos;
  logic        tag_match;
  frame_rec_t  stg_frame;
  frame_rec_t  kept_frame;
  jfif_rec_t   stg_jfif;
  jfif_rec_t   kept_jfif;
  logic [23:0] stg_comp [COMPS];
  logic [23:0] kept_comp [COMPS];

  run_word_t   run_words_due [$];   // words the block still owes, oldest first
  logic [7:0]  file_bytes [$];      // file being assembled for sending
  logic [7:0]  seg_body [$];        // body of the segment being assembled

  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  int          hold_off_cycles = 0;
  int          mismatch_count = 0;

  always #5 clk = ~clk;

  jpeg_header_marker_parser dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .end_of_file     (end_of_file),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .last            (last),
    .baseline        (baseline),
    .precision       (precision),
    .image_width     (image_width),
    .image_height    (image_height),
    .component_count (component_count),
    .has_jfif        (has_jfif),
    .jfif_version    (jfif_version),
    .density_units   (density_units),
    .x_density       (x_density),
    .y_density       (y_density),
    .component_entry (component_entry)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Frame markers are C0..CF, less DHT, JPG and DAC.
  function automatic logic frame_marker(input logic [7:0] c);
    return c >= jhmp_pkg::MK_SOF0 && c <= MK_SOF_LAST && c != jhmp_pkg::MK_DHT &&
           c != jhmp_pkg::MK_JPG && c != jhmp_pkg::MK_DAC;
  endfunction

  // Return to the state after reset: no frame, no JFIF, densities one.
  function automatic void clear_walk();
    walk_phase           = jhmp_pkg::PH_SOI0;
    seg_marker           = '0;
    seg_len              = '0;
    seg_pos              = '0;
    tag_match            = 1'b0;
    stg_frame            = '0;
    kept_frame           = '0;
    kept_frame.precision = 8'd8;
    stg_jfif             = '0;
    kept_jfif            = '0;
    kept_jfif.xd         = 16'd1;
    kept_jfif.yd         = 16'd1;
    for (int c = 0; c < COMPS; c++) begin
      stg_comp[c]  = '0;
      kept_comp[c] = '0;
    end
  endfunction

  // Stage one body byte into the frame or JFIF fields by its offset.
  function automatic void absorb_body_byte(input logic [7:0] b);
    int k;
    int slot;
    k = int'(seg_pos);
    if (frame_marker(seg_marker)) begin
      case (k)
        0: stg_frame.precision    = b;
        1: stg_frame.height[15:8] = b;
        2: stg_frame.height[7:0]  = b;
        3: stg_frame.width[15:8]  = b;
        4: stg_frame.width[7:0]   = b;
        5: stg_frame.count        = b;
        default: begin
          // component entries are three bytes: id, sampling, table
          slot = (k - 6) / 3;
          if (slot < COMPS) begin
            case ((k - 6) % 3)
              0:       stg_comp[slot][23:16] = b;
              1:       stg_comp[slot][15:8]  = b;
              default: stg_comp[slot][7:0]   = b;
            endcase
          end
        end
      endcase
    end else if (seg_marker == jhmp_pkg::MK_APP0) begin
      if (k < 5) begin
        if (b != JFIF_ID[39 - 8 * k -: 8]) tag_match = 1'b0;
      end else begin
        case (k)
          5:  stg_jfif.version[15:8] = b;
          6:  stg_jfif.version[7:0]  = b;
          7:  stg_jfif.units         = b;
          8:  stg_jfif.xd[15:8]      = b;
          9:  stg_jfif.xd[7:0]       = b;
          10: stg_jfif.yd[15:8]      = b;
          11: stg_jfif.yd[7:0]       = b;
          default: ;
        endcase
      end
    end
  endfunction

  // A segment has fully arrived: promote what it staged.
  function automatic void commit_segment();
    int n;
    int room;
    if (frame_marker(seg_marker)) begin
      kept_frame.baseline = (seg_marker == jhmp_pkg::MK_SOF0);
      if (int'(seg_len) >= FRAME_HDR_LEN) begin
        // keep only entries lying wholly inside the segment
        room = (int'(seg_len) - FRAME_HDR_LEN) / 3;
        n    = int'(stg_frame.count);
        if (room < n) n = room;
        if (n > COMPS) n = COMPS;
        kept_frame.precision = stg_frame.precision;
        kept_frame.height    = stg_frame.height;
        kept_frame.width     = stg_frame.width;
        kept_frame.count     = stg_frame.count;
        kept_frame.kept      = 3'(n);
        for (int c = 0; c < n; c++) kept_comp[c] = stg_comp[c];
      end
    end else if (seg_marker == jhmp_pkg::MK_APP0 && int'(seg_len) >= JFIF_MIN_LEN &&
                 tag_match) begin
      kept_jfif         = stg_jfif;
      kept_jfif.present = 1'b1;
    end
  endfunction

  // Advance the marker walk by one file byte.
  function automatic void walk_byte(input logic [7:0] b);
    case (walk_phase)
      jhmp_pkg::PH_SOI0:
        walk_phase = (b == jhmp_pkg::MK_FILL) ? jhmp_pkg::PH_SOI1 : jhmp_pkg::PH_DONE;
      jhmp_pkg::PH_SOI1:
        walk_phase = (b == jhmp_pkg::MK_SOI) ? jhmp_pkg::PH_SCAN : jhmp_pkg::PH_DONE;
      jhmp_pkg::PH_SCAN: if (b == jhmp_pkg::MK_FILL) walk_phase = jhmp_pkg::PH_CODE;
      jhmp_pkg::PH_CODE: begin
        seg_marker = b;
        if (b == jhmp_pkg::MK_EOI || b == jhmp_pkg::MK_SOS) walk_phase = jhmp_pkg::PH_DONE;
        else if (b == jhmp_pkg::MK_STUF || (b >= jhmp_pkg::MK_RST0 && b <= jhmp_pkg::MK_RST7))
          walk_phase = jhmp_pkg::PH_SCAN;
        else walk_phase = jhmp_pkg::PH_LENHI;
      end
      jhmp_pkg::PH_LENHI: begin
        seg_len    = {b, 8'h00};
        walk_phase = jhmp_pkg::PH_LENLO;
      end
      jhmp_pkg::PH_LENLO: begin
        seg_len[7:0] = b;
        seg_pos      = '0;
        tag_match    = 1'b1;
        if (int'(seg_len) < 2) begin
          walk_phase = jhmp_pkg::PH_DONE;
        end else if (int'(seg_len) == 2) begin
          commit_segment();
          walk_phase = jhmp_pkg::PH_SCAN;
        end else begin
          walk_phase = jhmp_pkg::PH_BODY;
        end
      end
      jhmp_pkg::PH_BODY: begin
        absorb_body_byte(b);
        seg_pos = seg_pos + 16'd1;
        if (int'(seg_pos) + 2 >= int'(seg_len)) begin
          commit_segment();
          walk_phase = jhmp_pkg::PH_SCAN;
        end
      end
      default: ;  // walk over: ignore bytes until end of file
    endcase
  endfunction

  // On the end-of-file byte: queue one word per kept component, or a single word.
  function automatic void emit_run();
    run_word_t w;
    int        words;
    words = (kept_frame.kept > 3'd0) ? int'(kept_frame.kept) : 1;
    for (int r = 0; r < words; r++) begin
      w      = '0;
      w.last = (r == words - 1);
      // no frame at all: everything but last stays zero
      if (kept_frame.baseline || kept_frame.count != 8'd0) begin
        w.baseline        = kept_frame.baseline;
        w.precision       = kept_frame.precision;
        w.image_width     = kept_frame.width;
        w.image_height    = kept_frame.height;
        w.component_count = kept_frame.count;
        w.has_jfif        = kept_jfif.present;
        w.jfif_version    = kept_jfif.version;
        w.density_units   = kept_jfif.units;
        w.x_density       = kept_jfif.xd;
        w.y_density       = kept_jfif.yd;
        w.component_entry = (r < int'(kept_frame.kept)) ? kept_comp[r] : '0;
      end
      run_words_due = {run_words_due, w};
    end
    clear_walk();
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want_v);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want_v);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want_v);
    if (got !== want_v) note_mismatch(what, got, want_v);
  endtask

  // Compare each accepted word with the oldest one owed. Sample on the edge,
  // so the values seen are those that stood before it.
  always @(posedge clk) begin : result_check
    run_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (run_words_due.size() == 0) begin
        note_mismatch("unexpected result word", 32'(component_entry), '0);
      end else begin
        want = run_words_due.pop_front();
        check_field("last",            32'(last),            32'(want.last));
        check_field("baseline",        32'(baseline),        32'(want.baseline));
        check_field("precision",       32'(precision),       32'(want.precision));
        check_field("image_width",     32'(image_width),     32'(want.image_width));
        check_field("image_height",    32'(image_height),    32'(want.image_height));
        check_field("component_count", 32'(component_count), 32'(want.component_count));
        check_field("has_jfif",        32'(has_jfif),        32'(want.has_jfif));
        check_field("jfif_version",    32'(jfif_version),    32'(want.jfif_version));
        check_field("density_units",   32'(density_units),   32'(want.density_units));
        check_field("x_density",       32'(x_density),       32'(want.x_density));
        check_field("y_density",       32'(y_density),       32'(want.y_density));
        check_field("component_entry", 32'(component_entry), 32'(want.component_entry));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: when rx_idle is set, stall for a drawn number of cycles before each
  // word, or for a long hold-off when one is requested.
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    int n;
    forever begin
      n = rx_idle ? $urandom_range(0, 14) : 0;
      if (hold_off_cycles > 0) begin
        n               = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      // wait for a word to move, or for a hold-off request
      do @(posedge clk); while (!out_valid && hold_off_cycles == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one word and hold it until taken; predict on acceptance. Valid is
  // lowered only for a gap, so back-to-back words keep it high.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    end_of_file <= eof;
    do @(posedge clk); while (in_stall);
    walk_byte(b);
    if (eof) emit_run();
  endtask

  // Send the assembled file, end_of_file on its final byte.
  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++)
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    file_bytes.delete();
  endtask

  // Append a marker segment: pad or trim the staged body to the given length.
  task automatic put_segment(input logic [7:0] code, input int len);
    while (seg_body.size() < len - 2) seg_body = {seg_body, 8'($urandom)};
    while (seg_body.size() > len - 2 && seg_body.size() > 0) void'(seg_body.pop_back());
    file_bytes = {file_bytes, jhmp_pkg::MK_FILL, code, 8'(len >> 8), 8'(len)};
    file_bytes = {file_bytes, seg_body};
    seg_body.delete();
  endtask

  // Dimension or density value, leaning on the extremes now and then.
  function automatic logic [15:0] pick_wide();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Assemble a mostly well-formed file with random content; some are noise.
  task automatic build_random_file();
    int          kind;
    int          ncomp;
    int          len;
    int          decl;
    logic [7:0]  code;
    logic [7:0]  prec;
    logic [15:0] h;
    logic [15:0] w;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 6)) file_bytes = {file_bytes, 8'($urandom)};
      return;
    end
    file_bytes = {jhmp_pkg::MK_FILL, jhmp_pkg::MK_SOI};
    if ($urandom_range(0, 15) == 0) file_bytes[$urandom_range(0, 1)] = 8'($urandom);
    repeat ($urandom_range(0, 5)) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          // frame header, any C0..CF code so DHT, JPG and DAC turn up too
          code  = 8'($urandom_range(jhmp_pkg::MK_SOF0, MK_SOF_LAST));
          ncomp = $urandom_range(0, 5);
          decl  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                              : ncomp + $urandom_range(0, 2) - 1;
          len   = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 10)
                                              : FRAME_HDR_LEN + 3 * ncomp;
          prec  = ($urandom_range(0, 1) == 0) ? 8'd8 : 8'($urandom);
          h     = pick_wide();
          w     = pick_wide();
          seg_body = {prec, h[15:8], h[7:0], w[15:8], w[7:0], 8'(decl)};
          repeat (3 * ncomp) seg_body = {seg_body, 8'($urandom)};
          put_segment(code, len);
        end
        3, 4: begin
          // JFIF APP0, sometimes with a damaged tag or an odd length
          seg_body = {JFIF_ID[39:32], JFIF_ID[31:24], JFIF_ID[23:16], JFIF_ID[15:8],
                      JFIF_ID[7:0]};
          if ($urandom_range(0, 4) == 0) seg_body[$urandom_range(0, 4)] = 8'($urandom);
          h = pick_wide();
          w = pick_wide();
          seg_body = {seg_body, 8'($urandom_range(0, 2)), 8'($urandom),
                      8'($urandom_range(0, 3)), h[15:8], h[7:0], w[15:8], w[7:0]};
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 20) : JFIF_MIN_LEN;
          put_segment(jhmp_pkg::MK_APP0, len);
        end
        5: begin
          case ($urandom_range(0, 3))
            0:       code = jhmp_pkg::MK_DHT;
            1:       code = MK_DQT;
            2:       code = MK_APP1;
            default: code = MK_COM;
          endcase
          put_segment(code, $urandom_range(2, 7));
        end
        6: begin
          case ($urandom_range(0, 2))
            0: file_bytes = {file_bytes, jhmp_pkg::MK_FILL, jhmp_pkg::MK_STUF};
            1: file_bytes = {file_bytes, jhmp_pkg::MK_FILL,
                             8'(jhmp_pkg::MK_RST0 + $urandom_range(0, 7))};
            default: file_bytes = {file_bytes, 8'($urandom_range(0, 254))};
          endcase
        end
        7: put_segment(jhmp_pkg::MK_FILL, $urandom_range(2, 5));
        8: if ($urandom_range(0, 2) == 0) put_segment(MK_APP1, $urandom_range(0, 1));
        default: repeat ($urandom_range(1, 3)) file_bytes = {file_bytes, 8'($urandom)};
      endcase
    end
    // close with EOI, with SOS and scan bytes, by cutting it short, or not at all
    case ($urandom_range(0, 3))
      0: file_bytes = {file_bytes, jhmp_pkg::MK_FILL, jhmp_pkg::MK_EOI};
      1: begin
        file_bytes = {file_bytes, jhmp_pkg::MK_FILL, jhmp_pkg::MK_SOS};
        repeat ($urandom_range(0, 3)) file_bytes = {file_bytes, 8'($urandom)};
      end
      2: repeat ($urandom_range(1, 6)) begin
        if (file_bytes.size() > 1) void'(file_bytes.pop_back());
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ordinary baseline file: JFIF, three-component SOF0, DHT, then scan data.
  task automatic test_full_header();
    tx_idle    = 1'b0;
    rx_idle    = 1'b0;
    file_bytes = {jhmp_pkg::MK_FILL, jhmp_pkg::MK_SOI,
                  jhmp_pkg::MK_FILL, jhmp_pkg::MK_APP0, 8'h00, 8'h10,
                  8'h4A, 8'h46, 8'h49, 8'h46, 8'h00,
                  8'h01, 8'h02, 8'h01, 8'h00, 8'h48, 8'h00, 8'h48, 8'h00, 8'h00,
                  jhmp_pkg::MK_FILL, jhmp_pkg::MK_SOF0, 8'h00, 8'h11, 8'h08, 8'h00, 8'hF0,
                  8'h01, 8'h40,
                  8'h03, 8'h01, 8'h22, 8'h00, 8'h02, 8'h11, 8'h01, 8'h03, 8'h11, 8'h01,
                  jhmp_pkg::MK_FILL, jhmp_pkg::MK_DHT, 8'h00, 8'h03, 8'h00,
                  jhmp_pkg::MK_FILL, jhmp_pkg::MK_SOS, 8'h12, 8'h34, 8'h56};
    send_file();
  endtask

  // Extreme field values; six components declared, only four held.
  task automatic test_field_extremes();
    tx_idle    = 1'b1;
    rx_idle    = 1'b1;
    file_bytes = {jhmp_pkg::MK_FILL, jhmp_pkg::MK_SOI,
                  jhmp_pkg::MK_FILL, jhmp_pkg::MK_APP0, 8'h00, 8'h10,
                  8'h4A, 8'h46, 8'h49, 8'h46, 8'h00,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hAA, 8'h55,
                  jhmp_pkg::MK_FILL, MK_SOF_LAST, 8'h00, 8'h1A, 8'hFF, 8'hFF, 8'hFF,
                  8'hFF, 8'hFF,
                  8'h06, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h11, 8'h00,
                  8'h02, 8'h21, 8'h01, 8'h03, 8'h31, 8'h02, 8'h04, 8'h41, 8'h03,
                  jhmp_pkg::MK_FILL, jhmp_pkg::MK_EOI};
    send_file();
  endtask

  // Bad start: wrong first byte, wrong second byte, and a one-byte file.
  task automatic test_bad_start();
    file_bytes = {8'h00};
    send_file();
    file_bytes = {jhmp_pkg::MK_FILL, jhmp_pkg::MK_STUF, jhmp_pkg::MK_FILL, jhmp_pkg::MK_SOI,
                  jhmp_pkg::MK_FILL, jhmp_pkg::MK_SOF0};
    send_file();
    file_bytes = {jhmp_pkg::MK_FILL};
    send_file();
  endtask

  // No frame at all: zeroed single word.
  task automatic test_no_frame();
    file_bytes = {jhmp_pkg::MK_FILL, jhmp_pkg::MK_SOI, jhmp_pkg::MK_FILL, jhmp_pkg::MK_EOI};
    send_file();
  endtask

  // Skipped bytes, stuffing, restarts, a fill-byte segment, an empty APP0 and
  // a short frame that must only touch the baseline flag.
  task automatic test_marker_walk();
    tx_idle    = 1'b0;
    rx_idle    = 1'b1;
    file_bytes = {jhmp_pkg::MK_FILL, jhmp_pkg::MK_SOI, 8'h11,
                  jhmp_pkg::MK_FILL, jhmp_pkg::MK_STUF, jhmp_pkg::MK_FILL, jhmp_pkg::MK_RST0,
                  jhmp_pkg::MK_FILL, jhmp_pkg::MK_RST7, jhmp_pkg::MK_FILL, jhmp_pkg::MK_FILL,
                  8'h00, 8'h04, 8'hAA, 8'hBB,
                  jhmp_pkg::MK_FILL, MK_SOF1, 8'h00, 8'h08, 8'h0C, 8'hFF, 8'hFF, 8'h00,
                  8'h00, 8'h06,
                  jhmp_pkg::MK_FILL, jhmp_pkg::MK_APP0, 8'h00, 8'h02,
                  jhmp_pkg::MK_FILL, MK_SOF2, 8'h00, 8'h06, 8'h0C, 8'h12, 8'h34, 8'h56,
                  jhmp_pkg::MK_FILL, jhmp_pkg::MK_EOI};
    send_file();
  endtask

  // Short length, a truncated frame, a damaged JFIF tag and a frame with
  // room for fewer entries than it declares.
  task automatic test_segment_limits();
    tx_idle    = 1'b1;
    rx_idle    = 1'b0;
    file_bytes = {jhmp_pkg::MK_FILL, jhmp_pkg::MK_SOI, jhmp_pkg::MK_FILL, MK_DQT,
                  8'h00, 8'h01,
                  jhmp_pkg::MK_FILL, jhmp_pkg::MK_SOF0, 8'h00, 8'h08, 8'h08, 8'h00, 8'h01,
                  8'h00, 8'h01, 8'h01};
    send_file();
    file_bytes = {jhmp_pkg::MK_FILL, jhmp_pkg::MK_SOI, jhmp_pkg::MK_FILL, jhmp_pkg::MK_SOF0,
                  8'h00, 8'h0B, 8'h08, 8'h00, 8'h10,
                  8'h00, 8'h10, 8'h01, 8'h01, 8'h11};
    send_file();
    file_bytes = {jhmp_pkg::MK_FILL, jhmp_pkg::MK_SOI,
                  jhmp_pkg::MK_FILL, jhmp_pkg::MK_APP0, 8'h00, 8'h10,
                  8'h4A, 8'h46, 8'h58, 8'h46, 8'h00,
                  8'h01, 8'h01, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00,
                  jhmp_pkg::MK_FILL, jhmp_pkg::MK_SOF0, 8'h00, 8'h0E, 8'h08, 8'h00, 8'h02,
                  8'h00, 8'h03,
                  8'h03, 8'h01, 8'h11, 8'h00, 8'h02, 8'h22, 8'h01,
                  jhmp_pkg::MK_FILL, jhmp_pkg::MK_EOI};
    send_file();
  endtask

  // Hold the output off for a long stretch while tiny files keep coming, so
  // the record queue fills and the input stalls.
  task automatic test_input_backpressure();
    tx_idle         = 1'b0;
    rx_idle         = 1'b0;
    hold_off_cycles = 150;
    repeat (10) begin
      file_bytes = {jhmp_pkg::MK_FILL, jhmp_pkg::MK_SOI, jhmp_pkg::MK_FILL,
                    jhmp_pkg::MK_EOI};
      send_file();
    end
  endtask

  // Random files until the byte budget for this part has gone through.
  task automatic test_random_files();
    int sent_bytes;
    int sent_files;
    sent_bytes = 0;
    sent_files = 0;
    while (sent_bytes < 160 || sent_files < 6) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      build_random_file();
      sent_bytes += file_bytes.size();
      sent_files++;
      send_file();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run_sequence
    int guard;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    data_byte   <= '0;
    end_of_file <= 1'b0;
    clear_walk();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_full_header();
    test_field_extremes();
    test_bad_start();
    test_no_frame();
    test_marker_walk();
    test_segment_limits();
    test_input_backpressure();
    test_random_files();

    // drop valid, drain what is owed, then keep watching for strays
    in_valid <= 1'b0;
    guard = 0;
    while (run_words_due.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (run_words_due.size() != 0)
      note_mismatch("result words never arrived", 32'(run_words_due.size()), '0);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #6_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
